@@ design/lsb_first_bit_reader_top_macros.svh @@
// Assertion helpers for the bit reader top level.
`ifndef LSB_FIRST_BIT_READER_TOP_MACROS_SVH
`define LSB_FIRST_BIT_READER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LSBR_ASSERT_HOLD(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies an outcome in the next cycle.
`define LSBR_ASSERT_NEXT(label, cond, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
        else $error(msg);

`endif

@@ design/lsbr_pkg.sv @@
package lsbr_pkg;

    // Request modes carried in the slave-side tuser
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_REWIND = 2'd1;
    localparam logic [1:0] MODE_BITS   = 2'd2;
    localparam logic [1:0] MODE_COPY   = 2'd3;

    localparam int VALUE_W   = 32;
    localparam int SCRATCH_W = 64;
    localparam int FILL_W    = 7;
    localparam int LEN_CFG_W = 12;

    // Work done in the data stage, after the packet store read returns
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_BITS  = 3'd2,
        OP_BYTE  = 3'd3,
        OP_ERROR = 3'd4
    } op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               past_end;
        logic               last;
    } result_t;

endpackage

@@ design/lsb_first_bit_reader_top.sv @@
// LSB-first bit reader.
// Slave side (s_tvalid/s_tready/s_tdata/s_tuser) takes one request per beat; s_tuser
// holds the mode: write byte, rewind, read bits, aligned byte copy. The cfg channel
// loads buffer_length; write it only while no request is in flight.
// Master side gives one result beat per read-bits request, one beat per copied byte,
// and a single error beat (tuser set, tdata zero, tlast set) when a request runs past
// the valid length. Writes, rewinds and zero-length copies give no beat.
// The packet store is four byte-wide banks, so a refill fetches four bytes at any
// position in one access; the data stage merges them into the 64-bit scratch word.
// Throughput: one write, rewind or read-bits request per cycle while the output buffer
// has room. A copy holds s_tready low while its bank reads issue, one per cycle while
// there is room. A request's bank read and data stage are registered at the request
// edge; its result then goes into the output buffer, which raises m_tvalid.
// A two-entry output buffer parts the sides; when m_tready stays low the buffer
// fills and s_tready drops, and nothing is lost.
// Reset clears the reader position, scratch word and length; packet store contents
// are undefined until written and take no clearing pass.
`include "lsb_first_bit_reader_top_macros.svh"

module lsb_first_bit_reader_top #(
    parameter int BUFFER_BYTES   = 2048,
    parameter int MAX_COPY_BYTES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsbr_pkg::LEN_CFG_W-1:0]   cfg_data,   // buffer_length
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // address[10:0], byte_value[18:11], bit_count[24:19], byte_count[31:25]
    input  logic [31:0]                      s_tdata,
    input  logic [1:0]                       s_tuser,    // mode[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsbr_pkg::VALUE_W-1:0]     m_tdata,    // value[31:0]
    output logic [0:0]                       m_tuser,    // past_end[0]
    output logic                             m_tlast
);

    import lsbr_pkg::*;

    localparam int ROWS  = (BUFFER_BYTES + 3) / 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int POS_W = $clog2(BUFFER_BYTES + MAX_COPY_BYTES + 4) + 1;
    localparam int BIT_W = POS_W + 3;
    localparam int CNT_W = $clog2(MAX_COPY_BYTES + 1);

    // Configuration
    logic [POS_W-1:0] len_reg;

    // Reader position
    logic [POS_W-1:0]  fetch_reg, fetch_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SCRATCH_W-1:0] scratch_reg, scratch_next;

    // Copy sequencer
    logic             copy_busy_reg, copy_busy_next;
    logic [POS_W-1:0] copy_pos_reg, copy_pos_next;
    logic [CNT_W-1:0] copy_left_reg, copy_left_next;

    // Data stage
    logic        s1_valid_reg, s1_valid_next;
    op_t         s1_op_reg, s1_op_next;
    logic [5:0]  s1_bits_reg, s1_bits_next;
    logic [FILL_W-1:0] s1_fill_reg, s1_fill_next;
    logic        s1_refill_reg, s1_refill_next;
    logic [1:0]  s1_lane_reg, s1_lane_next;
    logic [3:0]  s1_ok_reg, s1_ok_next;
    logic        s1_last_reg, s1_last_next;

    // Output buffer
    result_t     obuf_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  ocnt_reg;

    // Request fields
    logic [1:0]  mode;
    logic [10:0] address;
    logic [7:0]  byte_value;
    logic [5:0]  bit_count;
    logic [6:0]  byte_count;

    logic [5:0]       bits_sat;
    logic [CNT_W-1:0] cnt_sat;
    logic [BIT_W-1:0] fetch8;
    logic [BIT_W-1:0] total8;
    logic             rd_past;
    logic             refill;
    logic [POS_W-1:0] start;
    logic             cp_past;

    logic        pop, push, s_accept, copy_issue, issue_ok;
    logic [2:0]  occ_after;
    result_t     s1_result;

    logic            bank_we [4];
    logic [ROW_W-1:0] bank_waddr;
    logic [ROW_W-1:0] bank_raddr [4];
    logic [7:0]      bank_rdata [4];
    logic            bank_re;

    assign mode       = s_tuser;
    assign address    = s_tdata[10:0];
    assign byte_value = s_tdata[18:11];
    assign bit_count  = s_tdata[24:19];
    assign byte_count = s_tdata[31:25];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (32'(cfg_data) < BUFFER_BYTES)
            begin
                len_reg <= POS_W'(cfg_data);
            end
            else
            begin
                len_reg <= POS_W'(BUFFER_BYTES);
            end
        end
    end

    // Issue control
    assign pop       = m_tvalid && m_tready;
    assign occ_after = {1'b0, ocnt_reg} + {2'b00, s1_valid_reg} - {2'b00, pop};
    assign issue_ok  = (occ_after <= 3'd1);
    assign s_tready  = !copy_busy_reg && issue_ok;
    assign s_accept  = s_tvalid && s_tready;
    assign copy_issue = copy_busy_reg && issue_ok;

    always_comb
    begin
        if (bit_count == 6'd0)
        begin
            bits_sat = 6'd1;
        end
        else if (bit_count > 6'd32)
        begin
            bits_sat = 6'd32;
        end
        else
        begin
            bits_sat = bit_count;
        end
        if (32'(byte_count) > MAX_COPY_BYTES)
        begin
            cnt_sat = CNT_W'(MAX_COPY_BYTES);
        end
        else
        begin
            cnt_sat = CNT_W'(byte_count);
        end
    end

    assign fetch8  = {fetch_reg, 3'b000};
    assign total8  = {len_reg, 3'b000};
    assign rd_past = (BIT_W'(bits_sat) + fetch8) > (total8 + BIT_W'(fill_reg));
    assign refill  = fill_reg < FILL_W'(bits_sat);
    // Round up to the next byte boundary: drop whole bytes still in scratch
    assign start   = fetch_reg - POS_W'(fill_reg[FILL_W-1:3]);
    assign cp_past = (start + POS_W'(cnt_sat)) > len_reg;

    // Position update and data stage setup
    always_comb
    begin
        fetch_next     = fetch_reg;
        fill_next      = fill_reg;
        copy_busy_next = copy_busy_reg;
        copy_pos_next  = copy_pos_reg;
        copy_left_next = copy_left_reg;
        s1_valid_next  = 1'b0;
        s1_op_next     = OP_NONE;
        s1_bits_next   = bits_sat;
        s1_fill_next   = fill_reg;
        s1_refill_next = 1'b0;
        s1_lane_next   = fetch_reg[1:0];
        s1_ok_next     = '0;
        s1_last_next   = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s1_ok_next[i] = (fetch_reg + POS_W'(i)) < len_reg;
        end

        if (copy_issue)
        begin
            s1_valid_next  = 1'b1;
            s1_op_next     = OP_BYTE;
            s1_lane_next   = copy_pos_reg[1:0];
            s1_last_next   = (copy_left_reg == CNT_W'(1));
            copy_pos_next  = copy_pos_reg + POS_W'(1);
            copy_left_next = copy_left_reg - CNT_W'(1);
            if (copy_left_reg == CNT_W'(1))
            begin
                copy_busy_next = 1'b0;
            end
        end
        else if (s_accept)
        begin
            s1_valid_next = 1'b1;
            unique case (mode)
                MODE_WRITE:
                begin
                    s1_op_next = OP_NONE;
                end
                MODE_REWIND:
                begin
                    s1_op_next = OP_CLEAR;
                    fetch_next = '0;
                    fill_next  = '0;
                end
                MODE_BITS:
                begin
                    if (rd_past)
                    begin
                        s1_op_next = OP_ERROR;
                    end
                    else
                    begin
                        s1_op_next     = OP_BITS;
                        s1_refill_next = refill;
                        if (refill)
                        begin
                            fetch_next = fetch_reg + POS_W'(4);
                            fill_next  = fill_reg + FILL_W'(32) - FILL_W'(bits_sat);
                        end
                        else
                        begin
                            fill_next = fill_reg - FILL_W'(bits_sat);
                        end
                    end
                end
                MODE_COPY:
                begin
                    if (cp_past)
                    begin
                        s1_op_next = OP_ERROR;
                    end
                    else
                    begin
                        s1_op_next     = OP_CLEAR;
                        fetch_next     = start + POS_W'(cnt_sat);
                        fill_next      = '0;
                        copy_pos_next  = start;
                        copy_left_next = cnt_sat;
                        copy_busy_next = (cnt_sat != '0);
                    end
                end
                default:
                begin
                    s1_op_next = OP_NONE;
                end
            endcase
        end
    end

    // Bank addressing: a refill takes four consecutive bytes from any offset
    assign bank_re    = s_accept || copy_issue;
    assign bank_waddr = ROW_W'(address >> 2);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [1:0]       off;
        logic [POS_W-1:0] pos;

        assign off = 2'(b) - fetch_reg[1:0];
        assign pos = fetch_reg + POS_W'(off);
        assign bank_raddr[b] = copy_busy_reg ? copy_pos_reg[ROW_W+1:2] : pos[ROW_W+1:2];
        assign bank_we[b] = s_accept && (mode == MODE_WRITE)
                            && (32'(address) < BUFFER_BYTES) && (address[1:0] == 2'(b));

        lsbr_ram #(
            .WIDTH(8),
            .DEPTH(ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr),
            .wdata (byte_value),
            .re    (bank_re),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    // Data stage: merge refill, extract bits, shift scratch; clear scratch, pass copied bytes, flag errors
    always_comb
    begin
        logic [31:0]          word;
        logic [SCRATCH_W-1:0] merged;
        logic [SCRATCH_W-1:0] mask;
        logic [1:0]           lane;

        for (int i = 0; i < 4; i++)
        begin
            lane = s1_lane_reg + 2'(i);
            word[8*i +: 8] = bank_rdata[lane] & {8{s1_ok_reg[i]}};
        end
        merged = scratch_reg;
        if (s1_refill_reg)
        begin
            merged = scratch_reg | (SCRATCH_W'(word) << s1_fill_reg);
        end
        mask = (SCRATCH_W'(1) << s1_bits_reg) - SCRATCH_W'(1);

        scratch_next = scratch_reg;
        push         = 1'b0;
        s1_result    = '{value: '0, past_end: 1'b0, last: 1'b1};
        if (s1_valid_reg)
        begin
            case (s1_op_reg)
                OP_CLEAR:
                begin
                    scratch_next = '0;
                end
                OP_BITS:
                begin
                    scratch_next    = merged >> s1_bits_reg;
                    push            = 1'b1;
                    s1_result.value = merged[VALUE_W-1:0] & mask[VALUE_W-1:0];
                end
                OP_BYTE:
                begin
                    push            = 1'b1;
                    s1_result.value = VALUE_W'(bank_rdata[s1_lane_reg]);
                    s1_result.last  = s1_last_reg;
                end
                OP_ERROR:
                begin
                    push               = 1'b1;
                    s1_result.past_end = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_reg     <= '0;
            fill_reg      <= '0;
            scratch_reg   <= '0;
            copy_busy_reg <= 1'b0;
            copy_pos_reg  <= '0;
            copy_left_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= OP_NONE;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            ocnt_reg      <= '0;
        end
        else
        begin
            fetch_reg     <= fetch_next;
            fill_reg      <= fill_next;
            scratch_reg   <= scratch_next;
            copy_busy_reg <= copy_busy_next;
            copy_pos_reg  <= copy_pos_next;
            copy_left_reg <= copy_left_next;
            s1_valid_reg  <= s1_valid_next;
            s1_op_reg     <= s1_op_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            ocnt_reg <= ocnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bits_reg   <= s1_bits_next;
        s1_fill_reg   <= s1_fill_next;
        s1_refill_reg <= s1_refill_next;
        s1_lane_reg   <= s1_lane_next;
        s1_ok_reg     <= s1_ok_next;
        s1_last_reg   <= s1_last_next;
        if (push)
        begin
            obuf_reg[wr_ptr_reg] <= s1_result;
        end
    end

    assign m_tvalid   = (ocnt_reg != 2'd0);
    assign m_tdata    = obuf_reg[rd_ptr_reg].value;
    assign m_tuser[0] = obuf_reg[rd_ptr_reg].past_end;
    assign m_tlast    = obuf_reg[rd_ptr_reg].last;

    `LSBR_ASSERT_HOLD(a_obuf_no_overflow, !(push && ocnt_reg == 2'd2 && !pop),
        "output buffer overflow")
    `LSBR_ASSERT_HOLD(a_consumed_nonneg, fetch8 >= BIT_W'(fill_reg),
        "scratch holds more bits than were fetched")
    `LSBR_ASSERT_HOLD(a_error_beat, !(m_tvalid && m_tuser[0]) || (m_tlast && m_tdata == '0),
        "error beat carries data or lacks last")
    `LSBR_ASSERT_NEXT(a_copy_ends, copy_issue && copy_left_reg == CNT_W'(1), !copy_busy_reg,
        "copy sequencer did not stop after last byte")

endmodule

@@ design/lsbr_ram.sv @@
module lsbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
